>>> rtl/core/aip_pkg.sv
package aip_pkg;

	// Widths fixed by the item and register layouts.
	localparam int unsigned CHAR_W       = 8;
	localparam int unsigned OUT_VALUE_W  = 32;
	localparam int unsigned OUT_OFFSET_W = 10;
	localparam int unsigned S_TDATA_W    = 8;
	localparam int unsigned M_TDATA_W    = 48;
	localparam int unsigned BASE_W       = 5;
	localparam int unsigned CFG_ADDR_W   = 3;
	localparam int unsigned CFG_DATA_W   = 32;

	// Register index, taken from paddr[2] (registers sit 4 bytes apart).
	typedef logic [0:0] reg_idx_t;
	localparam reg_idx_t REG_NUMBER_BASE = 1'b0;
	localparam reg_idx_t REG_SIGNED_MODE = 1'b1;

	// Characters the parser looks for.
	localparam logic [CHAR_W-1:0] CHAR_MINUS    = 8'h2D;
	localparam logic [CHAR_W-1:0] CHAR_ZERO     = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_NINE     = 8'h39;
	localparam logic [CHAR_W-1:0] CHAR_LOWER_A  = 8'h61;
	localparam logic [CHAR_W-1:0] CHAR_LOWER_F  = 8'h66;
	localparam logic [CHAR_W-1:0] CHAR_LOWER_X  = 8'h78;
	localparam logic [CHAR_W-1:0] CHAR_CASE_BIT = 8'h20;

	// Radixes chosen by prefix detection.
	localparam logic [BASE_W-1:0] BASE_AUTO = 5'd0;
	localparam logic [BASE_W-1:0] BASE_OCT  = 5'd8;
	localparam logic [BASE_W-1:0] BASE_DEC  = 5'd10;
	localparam logic [BASE_W-1:0] BASE_HEX  = 5'd16;

	typedef enum logic [6:0] {
		PH_IDLE     = 7'b0000001,
		PH_FIRST    = 7'b0000010,
		PH_NUMSTART = 7'b0000100,
		PH_ZERO16   = 7'b0001000,
		PH_ZERO0    = 7'b0010000,
		PH_XSEEN    = 7'b0100000,
		PH_DIGITS   = 7'b1000000
	} phase_t;

	typedef struct packed {
		logic       is_hex;
		logic [3:0] value;
	} digit_t;

	// Hex digit decode; lower and upper case letters fold together.
	function automatic digit_t decode_digit(input logic [CHAR_W-1:0] c);
		digit_t               d;
		logic [CHAR_W-1:0] lc;
		lc = c | CHAR_CASE_BIT;
		d.is_hex = 1'b0;
		d.value  = 4'd0;
		if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
			d.is_hex = 1'b1;
			d.value  = 4'(c - CHAR_ZERO);
		end else if (lc >= CHAR_LOWER_A && lc <= CHAR_LOWER_F) begin
			d.is_hex = 1'b1;
			d.value  = 4'(lc - CHAR_LOWER_A + 8'd10);
		end
		return d;
	endfunction

endpackage

>>> rtl/core/ascii_integer_parser.sv
// Channel   Direction  Beat contents
// s_*       in         tdata: character[7:0]; tuser: string_start
// m_*       out        tdata: parsed_value[31:0], stop_offset[41:32], zero pad[47:42]
// APB       in/out     reg 0 number_base at 0x0, reg 1 signed_mode at 0x4
//
// Every character beat is registered in the input register; one pass of
// decode, a VALUE_BITS by 5 bit multiply-add and the phase update then settles the
// parse state, and the result is written to the output register with that update.
// A beat may be taken every cycle; the input register refills while a result
// waits in the output register, and only a stall of both registers drops s_tready.
// arst_n clears the parse state to idle, number_base to 0 and signed_mode to 1.
module ascii_integer_parser #(
	parameter int unsigned VALUE_BITS = 32,
	parameter int unsigned MAX_OFFSET = 1023
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// Character stream in.
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [aip_pkg::S_TDATA_W-1:0]     s_tdata,   // [7:0] character
	input  logic                              s_tuser,   // [0] string_start
	// Result stream out.
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [aip_pkg::M_TDATA_W-1:0]     m_tdata,   // [31:0] parsed_value,
	                                                     // [41:32] stop_offset
	// Configuration port.
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [aip_pkg::CFG_ADDR_W-1:0]    paddr,
	input  logic [aip_pkg::CFG_DATA_W-1:0]    pwdata,
	output logic [aip_pkg::CFG_DATA_W-1:0]    prdata,
	output logic                              pready
);
	import aip_pkg::*;

	// Width of the character position counter, and widened views used to
	// fit the accumulator and the position onto the fixed output fields.
	localparam int unsigned POS_W = $clog2(MAX_OFFSET + 1);
	localparam int unsigned VAL_WIDE_W = (VALUE_BITS > OUT_VALUE_W) ? VALUE_BITS : OUT_VALUE_W;
	localparam int unsigned POS_WIDE_W = (POS_W > OUT_OFFSET_W) ? POS_W : OUT_OFFSET_W;

	// ---------------------------------------------------------------------
	// Configuration registers. Only paddr[2] selects; the port is always ready.
	// ---------------------------------------------------------------------
	logic [BASE_W-1:0] number_base_q;
	logic              signed_mode_q;
	logic              cfg_write;
	reg_idx_t          cfg_idx;

	assign pready    = 1'b1;
	assign cfg_idx   = paddr[2];
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			number_base_q <= BASE_AUTO;
			signed_mode_q <= 1'b1;
		end else if (cfg_write) begin
			unique case (cfg_idx)
				REG_NUMBER_BASE: number_base_q <= pwdata[BASE_W-1:0];
				REG_SIGNED_MODE: signed_mode_q <= pwdata[0];
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_NUMBER_BASE: prdata = {{(CFG_DATA_W-BASE_W){1'b0}}, number_base_q};
			REG_SIGNED_MODE: prdata = {{(CFG_DATA_W-1){1'b0}}, signed_mode_q};
		endcase
	end

	// ---------------------------------------------------------------------
	// Input register and flow control. The stage advances whenever the
	// output register is empty or being drained.
	// ---------------------------------------------------------------------
	logic              valid_s1;
	logic [CHAR_W-1:0] char_s1;
	logic              start_s1;
	logic              advance;
	logic              out_valid_q;

	assign advance  = !out_valid_q || m_tready;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			char_s1  <= s_tdata[CHAR_W-1:0];
			start_s1 <= s_tuser;
		end
	end

	// ---------------------------------------------------------------------
	// Parse state.
	// ---------------------------------------------------------------------
	phase_t                phase_q;
	logic [BASE_W-1:0]     base_q;
	logic [VALUE_BITS-1:0] acc_q;
	logic                  neg_q;
	logic [POS_W-1:0]      pos_q;

	// Values as seen by this beat, after a string start has cleared them.
	phase_t                phase_eff;
	logic [BASE_W-1:0]     base_eff;
	logic [VALUE_BITS-1:0] acc_eff;
	logic                  neg_eff;
	logic [POS_W-1:0]      pos_eff;

	phase_t                phase_n;
	logic [BASE_W-1:0]     base_n;
	logic [VALUE_BITS-1:0] acc_n;
	logic                  neg_n;

	digit_t                dig;
	logic                  is_x;
	logic                  num_start;
	logic                  take;
	logic [BASE_W-1:0]     take_base;
	logic                  emit;
	logic [POS_W-1:0]      emit_pos;
	logic [VALUE_BITS-1:0] result_value;
	logic [VAL_WIDE_W-1:0] value_wide;
	logic [POS_WIDE_W-1:0] pos_wide;

	assign dig  = decode_digit(char_s1);
	assign is_x = (char_s1 | CHAR_CASE_BIT) == CHAR_LOWER_X;

	always_comb begin
		// A string start restarts the parse at this character, wherever it was.
		if (start_s1) begin
			phase_eff = PH_FIRST;
			base_eff  = BASE_AUTO;
			acc_eff   = '0;
			neg_eff   = 1'b0;
			pos_eff   = '0;
		end else begin
			phase_eff = phase_q;
			base_eff  = base_q;
			acc_eff   = acc_q;
			neg_eff   = neg_q;
			if (phase_q != PH_IDLE && pos_q < POS_W'(MAX_OFFSET)) begin
				pos_eff = pos_q + 1'b1;
			end else begin
				pos_eff = pos_q;
			end
		end

		phase_n   = phase_eff;
		base_n    = base_eff;
		acc_n     = acc_eff;
		neg_n     = neg_eff;
		num_start = 1'b0;
		take      = 1'b0;
		take_base = base_eff;
		emit      = 1'b0;
		emit_pos  = pos_eff;

		unique case (phase_eff)
			PH_IDLE: begin
				phase_n = PH_IDLE;
			end
			PH_FIRST: begin
				if (signed_mode_q && char_s1 == CHAR_MINUS) begin
					neg_n   = 1'b1;
					phase_n = PH_NUMSTART;
				end else begin
					num_start = 1'b1;
				end
			end
			PH_NUMSTART: begin
				num_start = 1'b1;
			end
			PH_ZERO16: begin
				// Configured hex: a 0x prefix is dropped even with no digit after it.
				if (is_x) begin
					phase_n = PH_DIGITS;
				end else begin
					take = 1'b1;
				end
			end
			PH_ZERO0: begin
				if (is_x) begin
					phase_n = PH_XSEEN;
				end else begin
					take = 1'b1;
				end
			end
			PH_XSEEN: begin
				// Auto radix after 0x: a hex digit commits to hex, anything else
				// ends the parse with the value zero and the stop at the x.
				if (dig.is_hex) begin
					base_n    = BASE_HEX;
					take      = 1'b1;
					take_base = BASE_HEX;
				end else begin
					emit = 1'b1;
					if (pos_eff != '0) begin
						emit_pos = pos_eff - 1'b1;
					end else begin
						emit_pos = '0;
					end
				end
			end
			PH_DIGITS: begin
				take = 1'b1;
			end
			default: begin
				phase_n = PH_IDLE;
			end
		endcase

		// First character of the number proper: settle the radix.
		if (num_start) begin
			if (number_base_q == BASE_AUTO) begin
				if (char_s1 == CHAR_ZERO) begin
					base_n  = BASE_OCT;
					phase_n = PH_ZERO0;
				end else begin
					base_n    = BASE_DEC;
					take      = 1'b1;
					take_base = BASE_DEC;
				end
			end else begin
				base_n = number_base_q;
				if (number_base_q == BASE_HEX && char_s1 == CHAR_ZERO) begin
					phase_n = PH_ZERO16;
				end else begin
					take      = 1'b1;
					take_base = number_base_q;
				end
			end
		end

		// Digit step: accumulate, or stop at the first character out of range.
		if (take) begin
			phase_n = PH_DIGITS;
			if (dig.is_hex && {1'b0, dig.value} < take_base) begin
				acc_n = VALUE_BITS'(acc_eff * VALUE_BITS'(take_base)) + VALUE_BITS'(dig.value);
			end else begin
				emit     = 1'b1;
				emit_pos = pos_eff;
			end
		end

		if (emit) begin
			phase_n = PH_IDLE;
		end

		result_value = neg_eff ? (VALUE_BITS'(0) - acc_eff) : acc_eff;
		value_wide   = VAL_WIDE_W'(result_value);
		pos_wide     = POS_WIDE_W'(emit_pos);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			base_q  <= BASE_AUTO;
			acc_q   <= '0;
			neg_q   <= 1'b0;
			pos_q   <= '0;
		end else if (valid_s1 && advance) begin
			phase_q <= phase_n;
			base_q  <= base_n;
			acc_q   <= acc_n;
			neg_q   <= neg_n;
			pos_q   <= pos_eff;
		end
	end

	// ---------------------------------------------------------------------
	// Output register.
	// ---------------------------------------------------------------------
	logic [OUT_VALUE_W-1:0]  value_q;
	logic [OUT_OFFSET_W-1:0] offset_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1 && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && emit) begin
			value_q  <= value_wide[OUT_VALUE_W-1:0];
			offset_q <= pos_wide[OUT_OFFSET_W-1:0];
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(M_TDATA_W-OUT_VALUE_W-OUT_OFFSET_W){1'b0}}, offset_q, value_q};

`ifndef SYNTHESIS
	// A beat held in the input register that cannot move must block the input.
	a_hold_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |-> !s_tready)
		else $error("input taken while the input register is stalled");

	// Issuing a result always returns the parser to idle.
	a_emit_goes_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && advance && emit) |=> (phase_q == PH_IDLE))
		else $error("parser not idle after issuing a result");

	// While digits are read the radix has been settled to a nonzero value.
	a_digits_have_base: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DIGITS) |-> (base_q != BASE_AUTO))
		else $error("digit phase with no radix");

	// The position counter saturates and never runs past its limit.
	a_pos_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_W'(MAX_OFFSET))
		else $error("character position beyond its limit");
`endif

endmodule
